// ----- rtl/pre_pkg.sv -----
// Shared types and constants of the polyhedron radius engine.
`default_nettype none

package pre_pkg;

  localparam int COORD_W    = 24;
  localparam int SLOT_W     = 8;
  localparam int RAD_W      = 23;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  localparam int MUL_W  = 31;
  localparam int PROD_W = 62;
  localparam int ACC_W  = 64;
  localparam int NRM_W  = 51;
  localparam int UN_W   = 30;
  localparam int DM_W   = 56;
  localparam int QUO_W  = 23;
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int CNT_W  = 5;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FACE   = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [RAD_W-1:0] RAD_MAX        = 23'h7FFFFF;
  localparam logic [RAD_W-1:0] INRADIUS_RESET = 23'd6553600;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_FACE,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [SLOT_W-1:0]  c0;
    logic [SLOT_W-1:0]  c1;
    logic [SLOT_W-1:0]  c2;
    logic [2:0]         c_ok;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LSQ,
    B_LROOT,
    B_RD,
    B_DIFF,
    B_CROSS,
    B_MAG,
    B_NORM,
    B_SD,
    B_FROOT,
    B_DCHK,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/pre_front.sv -----
// Front end: accepts input transfers, classifies them and queues commands.
`default_nettype none

module pre_front #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [pre_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [pre_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                              q_valid,
  output pre_pkg::cmd_t                     q_cmd,
  input  wire logic                         q_pop
);
  import pre_pkg::*;

  cmd_t       cmd_in;
  logic       keep;
  logic       push;
  cmd_t       fifo [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    slot_ok = ({24'd0, s} < 32'(MAX_VERTICES));
  endfunction

  always_comb begin
    cmd_in.kind = CMD_LOAD;
    cmd_in.slot = s_axis_tdata[7:0];
    cmd_in.x    = s_axis_tdata[31:8];
    cmd_in.y    = s_axis_tdata[55:32];
    cmd_in.z    = s_axis_tdata[79:56];
    cmd_in.c0   = s_axis_tdata[87:80];
    cmd_in.c1   = s_axis_tdata[95:88];
    cmd_in.c2   = s_axis_tdata[103:96];
    cmd_in.c_ok = {slot_ok(cmd_in.c2), slot_ok(cmd_in.c1), slot_ok(cmd_in.c0)};
    keep = 1'b0;
    case (s_axis_tuser)
      OP_LOAD: begin
        cmd_in.kind = CMD_LOAD;
        keep = slot_ok(cmd_in.slot);
      end
      OP_FACE: begin
        cmd_in.kind = CMD_FACE;
        keep = 1'b1;
      end
      OP_FINISH: begin
        cmd_in.kind = CMD_FINISH;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (count != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready && keep;
  assign q_valid = (count != 2'd0);
  assign q_cmd = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pre_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none

module pre_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [pre_pkg::SQ_IN_W-1:0]  radicand,
  output logic                              done,
  output logic [pre_pkg::SQ_OUT_W-1:0]      root
);
  import pre_pkg::*;

  logic [SQ_IN_W-1:0] v;
  logic [33:0]        rem;
  logic [35:0]        rem2;
  logic [35:0]        trial;
  logic [CNT_W-1:0]   cnt;
  logic               run;

  assign rem2  = {rem, v[SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      v <= {v[SQ_IN_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem  <= 34'(rem2 - trial);
        root <= {root[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem  <= rem2[33:0];
        root <= {root[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 5'd31);
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pre_back.sv -----
// Back end: vertex store, shared multiplier, plane distance and radius tracking.
`default_nettype none

module pre_back #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  input  wire pre_pkg::cmd_t             q_cmd,
  output logic                           q_pop,
  input  wire logic                      cfg_valid,
  input  wire logic [pre_pkg::RAD_W-1:0] cfg_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [pre_pkg::RAD_W-1:0]      inner_radius,
  output logic [pre_pkg::RAD_W-1:0]      outer_radius
);
  import pre_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  back_state_t state;
  back_state_t state_next;
  logic [CNT_W-1:0] cnt;
  cmd_t cmd;

  logic [3*COORD_W-1:0] vmem [MAX_VERTICES];
  logic [3*COORD_W-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;

  logic [COORD_W-1:0] p0 [3];
  logic [COORD_W-1:0] p1 [3];
  logic [COORD_W-1:0] p2 [3];
  logic [COORD_W:0]   av [3];
  logic [COORD_W:0]   bv [3];
  logic [NRM_W-1:0]   n  [3];
  logic [NRM_W-1:0]   u  [3];
  logic               neg [3];
  logic [MUL_W-1:0]   mv [3];
  logic [NRM_W-1:0]   orv;
  logic               shr;
  logic               shl;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_d;
  logic [ACC_W-1:0]         lsum;
  logic [ACC_W-1:0]         dsum;
  logic [ACC_W-1:0]         dabs;

  logic                  sq_start;
  logic [SQ_IN_W-1:0]    sq_rad;
  logic                  sq_done;
  logic [SQ_OUT_W-1:0]   sq_root;

  logic [SQ_OUT_W-1:0] rootv;
  logic [DM_W-1:0]     dmag;
  logic [32:0]         rem;
  logic [33:0]         tdiv;
  logic                qbit;
  logic [QUO_W-1:0]    dsh;
  logic [QUO_W-1:0]    quo;
  logic [QUO_W-1:0]    qfin;
  logic                sat;
  logic [RAD_W-1:0]    vdist;

  logic [RAD_W-1:0] min_d;
  logic [RAD_W-1:0] max_d;
  logic [RAD_W-1:0] start_r;

  function automatic logic [MUL_W-1:0] ext_c(input logic [COORD_W-1:0] v);
    ext_c = {{(MUL_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [MUL_W-1:0] ext_d(input logic [COORD_W:0] v);
    ext_d = {{(MUL_W-COORD_W-1){v[COORD_W]}}, v};
  endfunction

  pre_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Vertex store: one write port for loads, one registered read port for faces.
  assign mem_we = (state == B_IDLE) && q_valid && (q_cmd.kind == CMD_LOAD);

  always_comb begin
    case (cnt)
      5'd0:    rd_addr = AW'(cmd.c0);
      5'd1:    rd_addr = AW'(cmd.c1);
      default: rd_addr = AW'(cmd.c2);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[AW'(q_cmd.slot)] <= {q_cmd.z, q_cmd.y, q_cmd.x};
    end
    rd_data <= vmem[rd_addr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mv[i] = neg[i] ? MUL_W'(-{1'b0, u[i][UN_W-1:0]}) : {1'b0, u[i][UN_W-1:0]};
    end
    orv = u[0] | u[1] | u[2];
    shr = |orv[NRM_W-1:UN_W];
    shl = !shr && !orv[UN_W-1];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_LSQ: begin
        case (cnt)
          5'd0: begin
            mul_a = ext_c(cmd.x);
            mul_b = ext_c(cmd.x);
          end
          5'd1: begin
            mul_a = ext_c(cmd.y);
            mul_b = ext_c(cmd.y);
          end
          default: begin
            mul_a = ext_c(cmd.z);
            mul_b = ext_c(cmd.z);
          end
        endcase
      end
      B_CROSS: begin
        case (cnt)
          5'd0: begin
            mul_a = ext_d(av[1]);
            mul_b = ext_d(bv[2]);
          end
          5'd1: begin
            mul_a = ext_d(av[2]);
            mul_b = ext_d(bv[1]);
          end
          5'd2: begin
            mul_a = ext_d(av[2]);
            mul_b = ext_d(bv[0]);
          end
          5'd3: begin
            mul_a = ext_d(av[0]);
            mul_b = ext_d(bv[2]);
          end
          5'd4: begin
            mul_a = ext_d(av[0]);
            mul_b = ext_d(bv[1]);
          end
          default: begin
            mul_a = ext_d(av[1]);
            mul_b = ext_d(bv[0]);
          end
        endcase
      end
      B_SD: begin
        case (cnt)
          5'd0: begin
            mul_a = mv[0];
            mul_b = mv[0];
          end
          5'd1: begin
            mul_a = mv[1];
            mul_b = mv[1];
          end
          5'd2: begin
            mul_a = mv[2];
            mul_b = mv[2];
          end
          5'd3: begin
            mul_a = mv[0];
            mul_b = ext_c(p0[0]);
          end
          5'd4: begin
            mul_a = mv[1];
            mul_b = ext_c(p0[1]);
          end
          default: begin
            mul_a = mv[2];
            mul_b = ext_c(p0[2]);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign lsum = ((cnt == 5'd1) ? '0 : acc) + prod_ext;
  assign dsum = ((cnt == 5'd4) ? '0 : acc_d) + prod_ext;
  assign dabs = acc_d[ACC_W-1] ? -acc_d : acc_d;
  assign vdist = (sq_root > {{(SQ_OUT_W-RAD_W){1'b0}}, RAD_MAX}) ? RAD_MAX : sq_root[RAD_W-1:0];
  assign sat = (dmag >= {1'b0, rootv, {QUO_W{1'b0}}});
  assign tdiv = {rem, dsh[QUO_W-1]};
  assign qbit = (tdiv >= {2'b00, rootv});
  assign qfin = {quo[QUO_W-2:0], qbit};

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    sq_start = 1'b0;
    sq_rad = acc;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_LOAD:   state_next = B_LSQ;
            CMD_FACE:   state_next = B_RD;
            CMD_FINISH: state_next = B_FIN;
            default:    state_next = B_IDLE;
          endcase
        end
      end
      B_LSQ: begin
        if (cnt == 5'd3) begin
          sq_start = 1'b1;
          sq_rad = lsum;
          state_next = B_LROOT;
        end
      end
      B_LROOT: begin
        if (sq_done) begin
          state_next = B_IDLE;
        end
      end
      B_RD: begin
        if (cnt == 5'd3) begin
          state_next = B_DIFF;
        end
      end
      B_DIFF:  state_next = B_CROSS;
      B_CROSS: begin
        if (cnt == 5'd6) begin
          state_next = B_MAG;
        end
      end
      B_MAG: begin
        // A face with an all-zero normal leaves the minimum alone.
        if (n[0] == '0 && n[1] == '0 && n[2] == '0) begin
          state_next = B_IDLE;
        end else begin
          state_next = B_NORM;
        end
      end
      B_NORM: begin
        if (!shr && !shl) begin
          state_next = B_SD;
        end
      end
      B_SD: begin
        if (cnt == 5'd6) begin
          sq_start = 1'b1;
          sq_rad = acc;
          state_next = B_FROOT;
        end
      end
      B_FROOT: begin
        if (sq_done) begin
          state_next = B_DCHK;
        end
      end
      B_DCHK: begin
        if (sat) begin
          state_next = B_IDLE;
        end else begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt == 5'(QUO_W - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt  <= (state_next != state) ? '0 : cnt + 5'd1;
    prod <= mul_a * mul_b;
    if (q_pop) begin
      cmd <= q_cmd;
    end
    case (state)
      B_LSQ: begin
        if (cnt != 5'd0) begin
          acc <= lsum;
        end
      end
      B_RD: begin
        case (cnt)
          5'd1: begin
            for (int i = 0; i < 3; i++) begin
              p0[i] <= cmd.c_ok[0] ? rd_data[i*COORD_W +: COORD_W] : '0;
            end
          end
          5'd2: begin
            for (int i = 0; i < 3; i++) begin
              p1[i] <= cmd.c_ok[1] ? rd_data[i*COORD_W +: COORD_W] : '0;
            end
          end
          5'd3: begin
            for (int i = 0; i < 3; i++) begin
              p2[i] <= cmd.c_ok[2] ? rd_data[i*COORD_W +: COORD_W] : '0;
            end
          end
          default: begin
          end
        endcase
      end
      B_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          av[i] <= {p1[i][COORD_W-1], p1[i]} - {p0[i][COORD_W-1], p0[i]};
          bv[i] <= {p2[i][COORD_W-1], p2[i]} - {p0[i][COORD_W-1], p0[i]};
        end
      end
      B_CROSS: begin
        case (cnt)
          5'd1, 5'd3, 5'd5: acc <= prod_ext;
          5'd2: n[0] <= NRM_W'(acc - prod_ext);
          5'd4: n[1] <= NRM_W'(acc - prod_ext);
          5'd6: n[2] <= NRM_W'(acc - prod_ext);
          default: begin
          end
        endcase
      end
      B_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= n[i][NRM_W-1];
          u[i]   <= n[i][NRM_W-1] ? -n[i] : n[i];
        end
      end
      B_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (shr) begin
            u[i] <= {1'b0, u[i][NRM_W-1:1]};
          end else if (shl) begin
            u[i] <= {u[i][NRM_W-2:0], 1'b0};
          end
        end
      end
      B_SD: begin
        if (cnt >= 5'd1 && cnt <= 5'd3) begin
          acc <= lsum;
        end else if (cnt >= 5'd4) begin
          acc_d <= dsum;
        end
      end
      B_FROOT: begin
        rootv <= sq_root;
        dmag  <= dabs[DM_W-1:0];
      end
      B_DCHK: begin
        rem <= dmag[DM_W-1:QUO_W];
        dsh <= dmag[QUO_W-1:0];
      end
      B_DIV: begin
        rem <= qbit ? 33'(tdiv - {2'b00, rootv}) : tdiv[32:0];
        dsh <= {dsh[QUO_W-2:0], 1'b0};
        quo <= qfin;
      end
      default: begin
      end
    endcase
  end

  // Running radii, start value and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_d <= INRADIUS_RESET;
      max_d <= '0;
      start_r <= INRADIUS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        start_r <= cfg_data;
      end
      if (state == B_LROOT && sq_done && vdist > max_d) begin
        max_d <= vdist;
      end
      if (state == B_DCHK && sat && RAD_MAX < min_d) begin
        min_d <= RAD_MAX;
      end
      if (state == B_DIV && cnt == 5'(QUO_W - 1) && qfin < min_d) begin
        min_d <= qfin;
      end
      if (state == B_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        min_d <= start_r;
        max_d <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_FIN && (!out_valid || out_ready)) begin
      inner_radius <= min_d;
      outer_radius <= max_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/polyhedron_radius_engine.sv -----
// Top level of the polyhedron radius engine.
`default_nettype none

// Streams vertex loads, triangular faces and finish commands (tuser 0, 1, 2;
// code 3 and loads to slots at or beyond MAX_VERTICES are taken and dropped).
// Faces read vertices from an internal store, so a face must only name slots
// loaded earlier. A finish returns the smallest face plane distance and the
// largest vertex distance from the origin, both unsigned Q7.16 saturated,
// then restarts them at the configured inradius start and zero. A two-entry
// command queue sits between the input and the arithmetic, and the result
// register lets work go on while a result waits. The arithmetic takes one
// item at a time: a vertex load runs three squarings on the shared
// multiplier and the 32-step square root, a finish loads the result
// register once it is free, and a face runs the one-bit-per-cycle
// normalizing shift of the normal (0 to 29 steps), the 32-step square root
// and the 23-step divider. A face whose distance saturates skips the
// divider, and a face with an all-zero normal skips the shift, root and divider.
// The configuration port is always ready and should be written while idle.
module polyhedron_radius_engine #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_slot, coord_x, coord_y, coord_z, corner_first, corner_second,
  // corner_third
  input  wire logic [pre_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic [pre_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // inner_radius, outer_radius, two zero bits
  output logic [pre_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pre_pkg::RAD_W-1:0]     cfg_data
);
  import pre_pkg::*;

  logic             q_valid;
  cmd_t             q_cmd;
  logic             q_pop;
  logic [RAD_W-1:0] inner_radius;
  logic [RAD_W-1:0] outer_radius;

  pre_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  pre_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .inner_radius (inner_radius),
    .outer_radius (outer_radius)
  );

  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {{(OUT_DATA_W-2*RAD_W){1'b0}}, outer_radius, inner_radius};

endmodule

`default_nettype wire

// ----- rtl/pre_checker.sv -----
// Port-level checks of the polyhedron radius engine and their binding.
`default_nettype none

module pre_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [pre_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pre_pkg::*;

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The padding above the two radii is always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:2*RAD_W] == '0)
    else $error("nonzero padding in result");

  // The command queue fills only through transfers, so input backpressure
  // follows an offered item.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready && !$past(rst) |-> $past(s_axis_tvalid) || $past(!s_axis_tready))
    else $error("input stalled without a preceding item");

endmodule

bind polyhedron_radius_engine pre_checker u_pre_checker (.*);

`default_nettype wire
